// ===== src/vpd_pkg.sv =====
// Shared types and constants for the varint packet deframer.
// Holds the result record carried from the parser through the result queue.
// No dependencies.
package vpd_pkg;

    localparam int MAX_VARINT_BYTES_DEF = 5;
    localparam int QUEUE_DEPTH_DEF      = 4;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_BODY   = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_VARINT_LONG = 2'd1;
    localparam logic [1:0] ERR_PAST_END    = 2'd2;
    localparam logic [1:0] ERR_EMPTY       = 2'd3;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  body_byte;
        logic [31:0] packet_id;
        logic [31:0] declared_length;
        logic        is_compressed;
        logic [1:0]  error_code;
        logic        last;
    } t_result;

endpackage

// ===== src/vpd_parser.sv =====
// Front end of the deframer: decodes the varint fields of each packet and
// classifies every accepted byte into at most one result record.
// Depends on vpd_pkg.
module vpd_parser #(
    parameter int MAX_VARINT_BYTES = vpd_pkg::MAX_VARINT_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_compression_enabled,
    input  logic             i_take,
    input  logic [7:0]       i_rx_byte,
    output logic             o_res_valid,
    output vpd_pkg::t_result o_res
);
    import vpd_pkg::*;

    localparam int SEEN_W = $clog2(MAX_VARINT_BYTES + 1);

    typedef enum logic [2:0] {
        PH_PLEN  = 3'd0,
        PH_DLEN  = 3'd1,
        PH_PID   = 3'd2,
        PH_BODY  = 3'd3,
        PH_BODYZ = 3'd4,
        PH_SKIP  = 3'd5,
        PH_HALT  = 3'd6
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [31:0]        r_value, n_value;
    logic [SEEN_W-1:0]  r_seen, n_seen;
    logic [31:0]        r_bytes_left, n_bytes_left;
    logic               r_comp_en, n_comp_en;

    logic [4:0]         w_shift;
    logic [31:0]        w_value;
    logic [SEEN_W-1:0]  w_seen_inc;
    logic               w_cont;
    logic               w_over;
    logic [31:0]        w_bl_dec;
    logic [31:0]        w_bl_body;

    // Each varint byte adds seven bits; groups beyond bit 31 fall off the top.
    assign w_shift    = 5'(r_seen) * 5'd7;
    assign w_value    = r_value | (32'(i_rx_byte[6:0]) << w_shift);
    assign w_seen_inc = r_seen + SEEN_W'(1);
    assign w_cont     = i_rx_byte[7];
    assign w_over     = w_cont && (w_seen_inc >= SEEN_W'(MAX_VARINT_BYTES));
    assign w_bl_dec   = r_bytes_left - 32'd1;
    assign w_bl_body  = (r_bytes_left != 32'd0) ? w_bl_dec : r_bytes_left;

    always_comb begin
        n_phase      = r_phase;
        n_value      = r_value;
        n_seen       = r_seen;
        n_bytes_left = r_bytes_left;
        n_comp_en    = i_cfg_valid ? i_cfg_compression_enabled : r_comp_en;
        o_res_valid  = 1'b0;
        o_res        = '0;

        if (i_take) begin
            unique case (r_phase)
                PH_PLEN: begin
                    n_value = w_value;
                    n_seen  = w_seen_inc;
                    if (w_over) begin
                        n_phase          = PH_HALT;
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = ERR_VARINT_LONG;
                        o_res.last       = 1'b1;
                    end else if (!w_cont) begin
                        n_bytes_left = w_value;
                        n_value      = '0;
                        n_seen       = '0;
                        if (w_value == 32'd0) begin
                            o_res_valid      = 1'b1;
                            o_res.kind       = KIND_ERROR;
                            o_res.error_code = ERR_EMPTY;
                            o_res.last       = 1'b1;
                        end else begin
                            n_phase = r_comp_en ? PH_DLEN : PH_PID;
                        end
                    end
                end

                PH_DLEN, PH_PID: begin
                    n_bytes_left = w_bl_dec;
                    n_value      = w_value;
                    n_seen       = w_seen_inc;
                    if (w_over || (w_cont && w_bl_dec == 32'd0) ||
                        (!w_cont && r_phase == PH_DLEN && w_value == 32'd0 &&
                         w_bl_dec == 32'd0)) begin
                        // Faulty field: report it and drop what is left of the packet.
                        n_phase          = (w_bl_dec == 32'd0) ? PH_PLEN : PH_SKIP;
                        n_value          = '0;
                        n_seen           = '0;
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = w_over ? ERR_VARINT_LONG : ERR_PAST_END;
                        o_res.last       = 1'b1;
                    end else if (!w_cont) begin
                        n_value = '0;
                        n_seen  = '0;
                        if (r_phase == PH_DLEN && w_value == 32'd0) begin
                            n_phase = PH_PID;
                        end else if (r_phase == PH_DLEN) begin
                            n_phase               = (w_bl_dec == 32'd0) ? PH_PLEN : PH_BODYZ;
                            o_res_valid           = 1'b1;
                            o_res.kind            = KIND_HEADER;
                            o_res.declared_length = w_value;
                            o_res.is_compressed   = 1'b1;
                            o_res.last            = (w_bl_dec == 32'd0);
                        end else begin
                            n_phase               = (w_bl_dec == 32'd0) ? PH_PLEN : PH_BODY;
                            o_res_valid           = 1'b1;
                            o_res.kind            = KIND_HEADER;
                            o_res.packet_id       = w_value;
                            o_res.declared_length = w_bl_dec;
                            o_res.last            = (w_bl_dec == 32'd0);
                        end
                    end
                end

                PH_BODY, PH_BODYZ, PH_SKIP: begin
                    n_bytes_left = w_bl_body;
                    if (w_bl_body == 32'd0) begin
                        n_phase = PH_PLEN;
                        n_value = '0;
                        n_seen  = '0;
                    end
                    if (r_phase != PH_SKIP) begin
                        o_res_valid         = 1'b1;
                        o_res.kind          = KIND_BODY;
                        o_res.body_byte     = i_rx_byte;
                        o_res.is_compressed = (r_phase == PH_BODYZ);
                        o_res.last          = (w_bl_body == 32'd0);
                    end
                end

                PH_HALT: begin
                    n_phase = PH_HALT;
                end

                default: begin
                    n_phase = PH_HALT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_PLEN;
            r_value      <= '0;
            r_seen       <= '0;
            r_bytes_left <= '0;
            r_comp_en    <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_value      <= n_value;
            r_seen       <= n_seen;
            r_bytes_left <= n_bytes_left;
            r_comp_en    <= n_comp_en;
        end
    end

endmodule

// ===== src/vpd_queue.sv =====
// Back end of the deframer: a small first-in first-out store of result
// records that presents the oldest one to the consumer. Depends on vpd_pkg.
module vpd_queue #(
    parameter int DEPTH = vpd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  vpd_pkg::t_result i_item,
    input  logic             i_rd,
    output vpd_pkg::t_result o_item,
    output logic             o_full,
    output logic             o_empty
);
    import vpd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_wr, w_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== src/varint_packet_deframer_core.sv =====
// Varint packet deframer, top level: one byte is taken per cycle; the result
// it causes is written to the result queue at that same edge and, if the queue
// was empty, shows on the result ports from the next cycle.
// Sustained throughput is one byte per cycle; only a full result queue
// (QUEUE_DEPTH entries, at least 2) holds off further bytes.
// Synchronous active-low reset empties the queue, turns compression off and
// restarts on a packet-length field.
module varint_packet_deframer_core #(
    parameter int MAX_VARINT_BYTES = vpd_pkg::MAX_VARINT_BYTES_DEF,
    parameter int QUEUE_DEPTH      = vpd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_compression_enabled,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_body_byte,
    output logic [31:0] o_packet_id,
    output logic [31:0] o_declared_length,
    output logic        o_is_compressed,
    output logic [1:0]  o_error_code,
    output logic        o_last
);
    import vpd_pkg::*;

    logic    w_take;
    logic    w_res_valid;
    t_result w_res;
    t_result w_head;

    assign o_cfg_ready = 1'b1;
    assign w_take      = push && !full;

    vpd_parser #(
        .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
    ) u_parser (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_cfg_valid               (i_cfg_valid),
        .i_cfg_compression_enabled (i_cfg_compression_enabled),
        .i_take                    (w_take),
        .i_rx_byte                 (i_rx_byte),
        .o_res_valid               (w_res_valid),
        .o_res                     (w_res)
    );

    vpd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_valid),
        .i_item  (w_res),
        .i_rd    (pop),
        .o_item  (w_head),
        .o_full  (full),
        .o_empty (empty)
    );

    assign o_kind            = w_head.kind;
    assign o_body_byte       = w_head.body_byte;
    assign o_packet_id       = w_head.packet_id;
    assign o_declared_length = w_head.declared_length;
    assign o_is_compressed   = w_head.is_compressed;
    assign o_error_code      = w_head.error_code;
    assign o_last            = w_head.last;

endmodule

// ===== verif/vpd_frame_checker.sv =====
// Checker for the varint packet deframer: predicts every result from the accepted bytes.
// It watches the byte, result and configuration channels and counts mismatches.
// Depends on vpd_pkg for the result record, the kind codes and the error codes.
module vpd_frame_checker #(
    parameter int MAX_VARINT_BYTES = vpd_pkg::MAX_VARINT_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_compression_enabled,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_body_byte,
    input  logic [31:0] i_packet_id,
    input  logic [31:0] i_declared_length,
    input  logic        i_is_compressed,
    input  logic [1:0]  i_error_code,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);
    import vpd_pkg::*;

    typedef enum logic [2:0] {
        P_LEN, P_DLEN, P_ID, P_BODY, P_BODY_Z, P_SKIP, P_HALT
    } t_parse_phase;

    typedef enum logic [1:0] {G_MORE, G_DONE, G_OVER} t_group_status;

    t_parse_phase phase = P_LEN;
    logic [31:0]  acc = '0;
    logic [2:0]   groups = '0;
    logic [31:0]  remaining = '0;
    logic         comp_en = 1'b0;
    t_result      expected_results[$];
    t_result      want;
    int           fail_count = 0;
    int           pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic t_result make_result(t_kind k, logic [7:0] body, logic [31:0] id,
                                            logic [31:0] len, logic comp, logic [1:0] err,
                                            logic last);
        t_result r;
        r.kind            = k;
        r.body_byte       = body;
        r.packet_id       = id;
        r.declared_length = len;
        r.is_compressed   = comp;
        r.error_code      = err;
        r.last            = last;
        return r;
    endfunction

    task automatic add_expected(input t_result r);
        expected_results = {expected_results, r};
    endtask

    task automatic take_group(input logic [7:0] b, output t_group_status st);
        int shift;
        shift = 7 * groups;
        // Groups that land beyond bit 31 are dropped.
        if (shift < 32) begin
            acc = acc | (32'(b[6:0]) << shift);
        end
        groups = groups + 3'd1;
        if (!b[7]) begin
            st = G_DONE;
        end else if (groups >= MAX_VARINT_BYTES) begin
            st = G_OVER;
        end else begin
            st = G_MORE;
        end
    endtask

    task automatic clear_field();
        acc    = '0;
        groups = '0;
    endtask

    // A field error skips what is left of the packet, if anything is.
    task automatic abort_packet(input logic [1:0] code);
        phase = (remaining == 0) ? P_LEN : P_SKIP;
        clear_field();
        add_expected(make_result(KIND_ERROR, 8'd0, 32'd0, 32'd0, 1'b0, code, 1'b1));
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        t_group_status st;
        case (phase)
            P_LEN: begin
                take_group(b, st);
                if (st == G_OVER) begin
                    phase = P_HALT;
                    add_expected(make_result(KIND_ERROR, 8'd0, 32'd0, 32'd0,
                                             1'b0, ERR_VARINT_LONG, 1'b1));
                end else if (st == G_DONE) begin
                    remaining = acc;
                    clear_field();
                    if (remaining == 0) begin
                        add_expected(make_result(KIND_ERROR, 8'd0, 32'd0,
                                                 32'd0, 1'b0, ERR_EMPTY, 1'b1));
                    end else begin
                        phase = comp_en ? P_DLEN : P_ID;
                    end
                end
            end
            P_DLEN, P_ID: begin
                remaining = remaining - 1;
                take_group(b, st);
                if (st == G_OVER) begin
                    abort_packet(ERR_VARINT_LONG);
                end else if (st == G_MORE) begin
                    if (remaining == 0) abort_packet(ERR_PAST_END);
                end else if (phase == P_DLEN) begin
                    if (acc == 0) begin
                        // A zero data length means an uncompressed id follows.
                        if (remaining == 0) begin
                            abort_packet(ERR_PAST_END);
                        end else begin
                            phase = P_ID;
                            clear_field();
                        end
                    end else begin
                        add_expected(make_result(KIND_HEADER, 8'd0, 32'd0, acc,
                                                 1'b1, ERR_NONE, remaining == 0));
                        phase = (remaining == 0) ? P_LEN : P_BODY_Z;
                        clear_field();
                    end
                end else begin
                    add_expected(make_result(KIND_HEADER, 8'd0, acc, remaining,
                                             1'b0, ERR_NONE, remaining == 0));
                    phase = (remaining == 0) ? P_LEN : P_BODY;
                    clear_field();
                end
            end
            P_BODY, P_BODY_Z: begin
                if (remaining != 0) remaining = remaining - 1;
                add_expected(make_result(KIND_BODY, b, 32'd0, 32'd0,
                                         phase == P_BODY_Z, ERR_NONE,
                                         remaining == 0));
                if (remaining == 0) begin
                    phase = P_LEN;
                    clear_field();
                end
            end
            P_SKIP: begin
                if (remaining != 0) remaining = remaining - 1;
                if (remaining == 0) begin
                    phase = P_LEN;
                    clear_field();
                end
            end
            default: begin
                phase = P_HALT;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name,
                     exp_val, act_val);
        end
    endtask

    // Results are compared before the byte of the same edge is predicted, since a
    // result never leaves in the cycle its byte arrives.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase     = P_LEN;
            remaining = '0;
            comp_en   = 1'b0;
            clear_field();
            expected_results.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, got kind %0d",
                             $time, i_kind);
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", 32'(want.kind), 32'(i_kind));
                    check_field("body_byte", 32'(want.body_byte), 32'(i_body_byte));
                    check_field("packet_id", want.packet_id, i_packet_id);
                    check_field("declared_length", want.declared_length, i_declared_length);
                    check_field("is_compressed", 32'(want.is_compressed),
                                32'(i_is_compressed));
                    check_field("error_code", 32'(want.error_code), 32'(i_error_code));
                    check_field("last", 32'(want.last), 32'(i_last));
                end
            end
            if (i_push && !i_full) parse_rx_byte(i_rx_byte);
            if (i_cfg_valid && i_cfg_ready) comp_en = i_cfg_compression_enabled;
        end
        pending_count = expected_results.size();
    end

endmodule

// ===== verif/tb_varint_packet_deframer_core.sv =====
// Testbench top for the varint packet deframer: drives framed byte streams and the
// compression setting, drains results with random stalls and gives the verdict.
// Depends on vpd_pkg, varint_packet_deframer_core and vpd_frame_checker.
module tb_varint_packet_deframer_core;

    localparam int QUIET_LIMIT = 600;
    localparam int RX_TARGET   = 950;
    localparam int VARINT_MAX  = vpd_pkg::MAX_VARINT_BYTES_DEF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_comp = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  rx_byte = 8'd0;
    logic        pop = 1'b0;
    logic        cfg_ready;
    logic        full;
    logic        empty;
    logic [1:0]  kind;
    logic [7:0]  body_byte;
    logic [31:0] packet_id;
    logic [31:0] declared_length;
    logic        is_compressed;
    logic [1:0]  error_code;
    logic        last;
    int          fail_count;
    int          pending;

    logic [7:0]  pkt_bytes[$];
    int          bytes_sent = 0;
    bit          comp_setting = 1'b0;
    bit          sender_burst = 1'b0;

    always #2 i_clk = ~i_clk;

    varint_packet_deframer_core dut (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_cfg_valid              (cfg_valid),
        .o_cfg_ready              (cfg_ready),
        .i_cfg_compression_enabled(cfg_comp),
        .push                     (push),
        .full                     (full),
        .i_rx_byte                (rx_byte),
        .empty                    (empty),
        .pop                      (pop),
        .o_kind                   (kind),
        .o_body_byte              (body_byte),
        .o_packet_id              (packet_id),
        .o_declared_length        (declared_length),
        .o_is_compressed          (is_compressed),
        .o_error_code             (error_code),
        .o_last                   (last)
    );

    vpd_frame_checker frame_check (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_cfg_valid              (cfg_valid),
        .i_cfg_ready              (cfg_ready),
        .i_cfg_compression_enabled(cfg_comp),
        .i_push                   (push),
        .i_full                   (full),
        .i_rx_byte                (rx_byte),
        .i_empty                  (empty),
        .i_pop                    (pop),
        .i_kind                   (kind),
        .i_body_byte              (body_byte),
        .i_packet_id              (packet_id),
        .i_declared_length        (declared_length),
        .i_is_compressed          (is_compressed),
        .i_error_code             (error_code),
        .i_last                   (last),
        .o_fail_count             (fail_count),
        .o_pending                (pending)
    );

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return 32'd0;
            1:       return 32'($urandom_range(1, 127));
            2:       return $urandom();
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    task automatic add_byte(input logic [7:0] b);
        pkt_bytes = {pkt_bytes, b};
    endtask

    // Appends a varint, now and then padded to more groups than it needs. A fifth
    // group carries random bits above bit 31, which the block must drop.
    task automatic add_varint(input logic [31:0] v);
        int n;
        logic [7:0] g;
        n = 1;
        while (n < VARINT_MAX && (v >> (7 * n)) != 0) n++;
        if ($urandom_range(0, 3) == 0) n = $urandom_range(n, VARINT_MAX);
        for (int i = 0; i < n; i++) begin
            g = 8'((v >> (7 * i)) & 32'h7F);
            if (i == 4) g[6:4] = 3'($urandom_range(0, 7));
            if (i < n - 1) g[7] = 1'b1;
            add_byte(g);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_packet();
        sender_burst = ($urandom_range(0, 3) == 0);
        foreach (pkt_bytes[i]) send_byte(pkt_bytes[i]);
        pkt_bytes.delete();
    endtask

    // The setting may only change once every result is out and the last byte
    // has had time to pass through the parser.
    task automatic write_cfg(input bit v);
        push <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
        cfg_comp  <= v;
        cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid    <= 1'b0;
        comp_setting = v;
    endtask

    initial begin : result_drain
        int gap;
        bit burst;
        burst = 1'b0;
        wait (i_rst_n);
        forever begin
            if ($urandom_range(0, 15) == 0) burst = !burst;
            gap = burst ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        int sel;
        int nbody;
        bit prefix;
        int next_cfg_at;
        logic [31:0] v;
        logic [7:0] content[$];

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Plain framing: empty packet, one body byte, widest id with dropped bits,
        // a field running past the end and an overlong id ending on the last byte.
        write_cfg(1'b0);
        pkt_bytes = {8'h00,
                     8'h02, 8'h00, 8'hFF,
                     8'h05, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
                     8'h02, 8'h80, 8'h80,
                     8'h05, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_packet();

        // Compressed framing: zero data length with an id, id missing after a zero
        // data length, and a compressed body passed through.
        write_cfg(1'b1);
        pkt_bytes = {8'h03, 8'h00, 8'h01, 8'h2A,
                     8'h01, 8'h00,
                     8'h03, 8'h05, 8'hAA, 8'h55};
        send_packet();

        next_cfg_at = bytes_sent + $urandom_range(40, 120);
        while (bytes_sent < RX_TARGET) begin
            sel = $urandom_range(0, 15);
            if (sel < 8) begin
                nbody = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 40)
                                                     : $urandom_range(0, 8);
                if (comp_setting && $urandom_range(0, 1) == 1) begin
                    v = pick_value();
                    if (v == 0) v = 32'd1;
                    add_varint(v);
                end else begin
                    if (comp_setting) add_varint(32'd0);
                    add_varint(pick_value());
                end
                repeat (nbody) add_byte(8'($urandom));
            end else if (sel < 10) begin
                // No content at all: the length field alone reads zero.
            end else if (sel < 12) begin
                if (comp_setting && $urandom_range(0, 1) == 1) add_byte(8'h00);
                repeat (VARINT_MAX) add_byte(8'h80 | 8'($urandom_range(0, 127)));
                repeat ($urandom_range(0, 4)) add_byte(8'($urandom));
            end else if (sel == 12) begin
                prefix = comp_setting && ($urandom_range(0, 1) == 1);
                if (prefix) add_byte(8'h00);
                repeat ($urandom_range(prefix ? 0 : 1, VARINT_MAX - 1))
                    add_byte(8'h80 | 8'($urandom_range(0, 127)));
            end else begin
                repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
            end

            content = pkt_bytes;
            pkt_bytes.delete();
            add_varint(32'(content.size()));
            pkt_bytes = {pkt_bytes, content};
            send_packet();

            if (bytes_sent >= next_cfg_at) begin
                write_cfg(($urandom_range(0, 3) == 0) ? comp_setting : !comp_setting);
                next_cfg_at = bytes_sent + $urandom_range(40, 120);
            end
        end

        // An overlong packet length halts the parser for good, so it comes last;
        // the bytes after it must give nothing.
        repeat (VARINT_MAX) add_byte(8'h80 | 8'($urandom_range(0, 127)));
        repeat (3) add_byte(8'($urandom));
        send_packet();
        push <= 1'b0;

        do @(negedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
